// File: rtl/core/ero_pkg.sv
// ---------------------------------------------------------------------------
// ero_pkg: shared types and constants for the Euler column rotator
// Fixed-point constants, CORDIC arctangent table and payload structs.
// ---------------------------------------------------------------------------
package ero_pkg;

  localparam int Steps = 30;

  localparam logic signed [34:0] PiQ30     = 35'sd3373259426;
  localparam logic signed [34:0] HalfPiQ30 = 35'sd1686629713;
  localparam logic signed [33:0] CordicK   = 34'sd652032875;
  localparam logic signed [33:0] Q30One    = 34'sd1073741824;
  localparam logic signed [16:0] RateFull  = 17'sd32767;

  typedef struct packed {
    logic signed [31:0] col_a;
    logic signed [31:0] col_b;
    logic signed [31:0] col_c;
    logic signed [15:0] rate_x;
    logic signed [15:0] rate_y;
    logic signed [15:0] rate_z;
    logic        [14:0] time_cap;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] new_a;
    logic signed [31:0] new_b;
    logic signed [31:0] new_c;
    logic signed [15:0] applied_x;
    logic signed [15:0] applied_y;
    logic signed [15:0] applied_z;
    logic               untouched;
  } out_item_t;

  // Arctangent of 2^-i in Q30
  function automatic logic signed [34:0] atan_q30(input logic [4:0] i);
    logic signed [34:0] v;
    case (i)
      5'd0:  v = 35'sd843314857;
      5'd1:  v = 35'sd497837829;
      5'd2:  v = 35'sd263043837;
      5'd3:  v = 35'sd133525159;
      5'd4:  v = 35'sd67021687;
      5'd5:  v = 35'sd33543516;
      5'd6:  v = 35'sd16775851;
      5'd7:  v = 35'sd8388437;
      5'd8:  v = 35'sd4194283;
      5'd9:  v = 35'sd2097149;
      default: v = 35'sd1 <<< (5'd30 - i);
    endcase
    return v;
  endfunction

endpackage

// File: rtl/core/ero_stream_if.sv
// ---------------------------------------------------------------------------
// ero_stream_if: valid/ready channel
// Carries one item payload per accepted handshake.
// ---------------------------------------------------------------------------
interface ero_stream_if #(parameter type item_t = logic);
  logic  valid;
  logic  ready;
  item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/core/ero_sincos_lane.sv
// ---------------------------------------------------------------------------
// ero_sincos_lane: pipelined sine/cosine of one clamped rate
// Angle scale, quadrant fold and a 30-stage CORDIC.
// ---------------------------------------------------------------------------
module ero_sincos_lane (
  input  logic               clk,
  input  logic               en,
  input  logic signed [15:0] rate,
  output logic signed [33:0] sin_q,
  output logic signed [33:0] cos_q
);

  localparam int Depth = ero_pkg::Steps;

  // stage 0: negated product -rate*pi (register after multiply)
  logic signed [50:0] prod;
  logic               zero0;
  // stage 1: divide by 32767 via reciprocal estimate and remainder correction
  logic signed [34:0] theta1;
  logic               zero1;

  logic signed [50:0] mag;
  logic        [50:0] umag, q_est, rem;
  logic        [34:0] q_fix;

  always_ff @(posedge clk) begin
    if (en) begin
      prod  <= -(51'(rate) * 51'(ero_pkg::PiQ30));
      zero0 <= (rate == 16'sd0);
    end
  end

  // truncating division by 32767: q ~ n/32768 * (1 + 2^-15 + 2^-30), which
  // never overshoots and falls short by at most 3, so the remainder fixes it
  always_comb begin
    mag   = prod[50] ? -prod : prod;
    umag  = mag;
    q_est = (umag >> 15) + (umag >> 30) + (umag >> 45);
    rem   = umag - q_est * 51'(ero_pkg::RateFull);
    q_fix = 35'(q_est);
    if (rem >= 51'd98301) q_fix = q_fix + 35'd3;       // 3 * 32767
    else if (rem >= 51'd65534) q_fix = q_fix + 35'd2;  // 2 * 32767
    else if (rem >= 51'd32767) q_fix = q_fix + 35'd1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      theta1 <= prod[50] ? -$signed(q_fix) : $signed(q_fix);
      zero1  <= zero0;
    end
  end

  // fold into [-pi/2, pi/2]
  logic signed [34:0] th_f;
  logic               flip_f;
  always_comb begin
    th_f   = theta1;
    flip_f = 1'b0;
    if (theta1 > ero_pkg::HalfPiQ30) begin
      th_f = theta1 - ero_pkg::PiQ30; flip_f = 1'b1;
    end else if (theta1 < -ero_pkg::HalfPiQ30) begin
      th_f = theta1 + ero_pkg::PiQ30; flip_f = 1'b1;
    end
  end

  // CORDIC pipeline
  logic signed [34:0] xs [Depth+1];
  logic signed [34:0] ys [Depth+1];
  logic signed [34:0] ts [Depth+1];
  logic               fl [Depth+1];
  logic               zr [Depth+1];

  always_ff @(posedge clk) begin
    if (en) begin
      xs[0] <= 35'(ero_pkg::CordicK);
      ys[0] <= '0;
      ts[0] <= th_f;
      fl[0] <= flip_f;
      zr[0] <= zero1 || (theta1 == 35'sd0);
    end
  end

  for (genvar g = 0; g < Depth; g++) begin : g_stage
    always_ff @(posedge clk) begin
      if (en) begin
        if (ts[g] >= 0) begin
          xs[g+1] <= xs[g] - (ys[g] >>> g);
          ys[g+1] <= ys[g] + (xs[g] >>> g);
          ts[g+1] <= ts[g] - ero_pkg::atan_q30(5'(g));
        end else begin
          xs[g+1] <= xs[g] + (ys[g] >>> g);
          ys[g+1] <= ys[g] - (xs[g] >>> g);
          ts[g+1] <= ts[g] + ero_pkg::atan_q30(5'(g));
        end
        fl[g+1] <= fl[g];
        zr[g+1] <= zr[g];
      end
    end
  end

  // output select: exact zero angle, sign flip
  always_comb begin
    if (zr[Depth]) begin
      sin_q = '0;
      cos_q = ero_pkg::Q30One;
    end else if (fl[Depth]) begin
      sin_q = 34'(-ys[Depth]);
      cos_q = 34'(-xs[Depth]);
    end else begin
      sin_q = 34'(ys[Depth]);
      cos_q = 34'(xs[Depth]);
    end
  end

endmodule

// File: rtl/core/ero_merge.sv
// ---------------------------------------------------------------------------
// ero_merge: matrix build and column product
// Combines the three lanes' sin/cos into R and forms R^T times the column.
// Stages: pair products, triple products and sums, element products, sum.
// ---------------------------------------------------------------------------
module ero_merge (
  input  logic               clk,
  input  logic               en,
  input  logic signed [33:0] sx, cx, sy, cy, sz, cz,
  input  logic signed [31:0] a, b, c,
  output logic signed [31:0] ra, rb, rc
);

  function automatic logic signed [33:0] qmul(input logic signed [33:0] p,
                                              input logic signed [33:0] q);
    logic signed [67:0] t;
    t = 68'(p) * 68'(q);
    return 34'(t >>> 30);
  endfunction

  // stage m0: pair products
  logic signed [33:0] szsx, czsx, czcy, szcx, czsy, szcy, czcx, szsy, cxsy, cxcy;
  logic signed [33:0] sy0, cy0, nsx0;
  logic signed [31:0] a0, b0, c0;
  always_ff @(posedge clk) begin
    if (en) begin
      szsx <= qmul(sz, sx); czsx <= qmul(cz, sx);
      czcy <= qmul(cz, cy); szcx <= qmul(sz, cx);
      czsy <= qmul(cz, sy); szcy <= qmul(sz, cy);
      czcx <= qmul(cz, cx); szsy <= qmul(sz, sy);
      cxsy <= qmul(cx, sy); cxcy <= qmul(cx, cy);
      sy0 <= sy; cy0 <= cy; nsx0 <= -sx;
      a0 <= a; b0 <= b; c0 <= c;
    end
  end

  // stage m1: matrix entries
  logic signed [34:0] x1, x2, x3, y1, y2, y3, z1, z2, z3;
  logic signed [31:0] a1, b1, c1;
  always_ff @(posedge clk) begin
    if (en) begin
      x1 <= 35'(czcy) + 35'(qmul(szsx, sy0));
      x2 <= 35'(szcx);
      x3 <= -35'(czsy) + 35'(qmul(szsx, cy0));
      y1 <= -35'(szcy) + 35'(qmul(czsx, sy0));
      y2 <= 35'(czcx);
      y3 <= 35'(szsy) + 35'(qmul(czsx, cy0));
      z1 <= 35'(cxsy);
      z2 <= 35'(nsx0);
      z3 <= 35'(cxcy);
      a1 <= a0; b1 <= b0; c1 <= c0;
    end
  end

  // stage m2: entry times element
  logic signed [66:0] p [9];
  always_ff @(posedge clk) begin
    if (en) begin
      p[0] <= 67'(x1) * 67'(a1); p[1] <= 67'(y1) * 67'(b1); p[2] <= 67'(z1) * 67'(c1);
      p[3] <= 67'(x2) * 67'(a1); p[4] <= 67'(y2) * 67'(b1); p[5] <= 67'(z2) * 67'(c1);
      p[6] <= 67'(x3) * 67'(a1); p[7] <= 67'(y3) * 67'(b1); p[8] <= 67'(z3) * 67'(c1);
    end
  end

  // stage m3: sum
  logic signed [68:0] s [3];
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        s[k] <= 69'(p[3*k]) + 69'(p[3*k+1]) + 69'(p[3*k+2]);
      end
    end
  end

  // truncate toward zero, saturate
  function automatic logic signed [31:0] finish(input logic signed [68:0] v);
    logic [68:0] m;
    logic signed [68:0] q;
    m = v[68] ? 69'(-v) : 69'(v);
    q = $signed(m >> 30);
    if (v[68]) q = -q;
    if (q > 69'sd2147483647) return 32'sh7fffffff;
    if (q < -69'sd2147483648) return 32'sh80000000;
    return 32'(q);
  endfunction

  assign ra = finish(s[0]);
  assign rb = finish(s[1]);
  assign rc = finish(s[2]);

endmodule

// File: rtl/core/euler_rotate_orientation_column_top.sv
// ---------------------------------------------------------------------------
// euler_rotate_orientation_column_top: Euler rotation of a matrix column
// Three sine/cosine lanes feed a merge stage that applies R^T.
// ---------------------------------------------------------------------------
// Usage:
//   in  : sink channel of ero_pkg::in_item_t (column, three rates, cap).
//   out : source channel of ero_pkg::out_item_t (rotated column, applied
//         rates, untouched flag).
// Each rate is clamped to the cap and turned into sin/cos by its own
// CORDIC lane; the merge stage builds R and multiplies the column.
// From acceptance to out an item passes one clamp register, the angle
// product and division registers, 31 CORDIC stages and 4 merge stages.
// Throughput is one item per cycle while out is not stalled.
// The whole pipeline advances only when the output register is empty or
// being taken, so a stall on out freezes every stage and in.ready drops;
// nothing is lost. Reset clears only the valid bits of the pipeline.
// ---------------------------------------------------------------------------
module euler_rotate_orientation_column_top (
  input logic clk,
  input logic rst,
  ero_stream_if.sink   in,
  ero_stream_if.source out
);

  localparam int Lat = 3 + ero_pkg::Steps + 1 + 4;

  logic en;
  logic vld [Lat];

  assign en       = !out.valid || out.ready;
  assign in.ready = en;

  // clamp stage
  logic signed [15:0] rx, ry, rz;
  logic signed [31:0] ca, cb, cc;
  logic               all_zero;
  always_ff @(posedge clk) begin
    if (en) begin
      rx <= (in.data.rate_x < -$signed({1'b0, in.data.time_cap})) ?
            -$signed({1'b0, in.data.time_cap}) :
            (in.data.rate_x > $signed({1'b0, in.data.time_cap})) ?
            $signed({1'b0, in.data.time_cap}) : in.data.rate_x;
      ry <= (in.data.rate_y < -$signed({1'b0, in.data.time_cap})) ?
            -$signed({1'b0, in.data.time_cap}) :
            (in.data.rate_y > $signed({1'b0, in.data.time_cap})) ?
            $signed({1'b0, in.data.time_cap}) : in.data.rate_y;
      rz <= (in.data.rate_z < -$signed({1'b0, in.data.time_cap})) ?
            -$signed({1'b0, in.data.time_cap}) :
            (in.data.rate_z > $signed({1'b0, in.data.time_cap})) ?
            $signed({1'b0, in.data.time_cap}) : in.data.rate_z;
      ca <= in.data.col_a; cb <= in.data.col_b; cc <= in.data.col_c;
      all_zero <= (in.data.rate_x == 16'sd0) && (in.data.rate_y == 16'sd0) &&
                  (in.data.rate_z == 16'sd0);
    end
  end

  // lanes
  logic signed [33:0] sx, cx, sy, cy, sz, cz;
  ero_sincos_lane u_lx (.clk, .en, .rate(rx), .sin_q(sx), .cos_q(cx));
  ero_sincos_lane u_ly (.clk, .en, .rate(ry), .sin_q(sy), .cos_q(cy));
  ero_sincos_lane u_lz (.clk, .en, .rate(rz), .sin_q(sz), .cos_q(cz));

  // side payload delay to match the lanes
  localparam int SideLen = 2 + ero_pkg::Steps + 1;
  ero_pkg::out_item_t side [SideLen];
  always_ff @(posedge clk) begin
    if (en) begin
      side[0] <= '{new_a: ca, new_b: cb, new_c: cc, applied_x: rx,
                   applied_y: ry, applied_z: rz, untouched: all_zero};
      for (int k = 1; k < SideLen; k++) side[k] <= side[k-1];
    end
  end

  logic signed [31:0] ra, rb, rc;
  ero_merge u_merge (
    .clk, .en,
    .sx, .cx, .sy, .cy, .sz, .cz,
    .a(side[SideLen-1].new_a), .b(side[SideLen-1].new_b), .c(side[SideLen-1].new_c),
    .ra, .rb, .rc
  );

  // delay of side payload through merge (4 stages)
  ero_pkg::out_item_t mside [4];
  always_ff @(posedge clk) begin
    if (en) begin
      mside[0] <= side[SideLen-1];
      for (int k = 1; k < 4; k++) mside[k] <= mside[k-1];
    end
  end

  // valid pipeline; last bit is the output register's valid
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < Lat; k++) vld[k] <= 1'b0;
    end else if (en) begin
      vld[0] <= in.valid;
      for (int k = 1; k < Lat; k++) vld[k] <= vld[k-1];
    end
  end

  // output select
  always_comb begin
    out.valid = vld[Lat-1];
    out.data  = mside[3];
    if (mside[3].untouched) begin
      out.data.applied_x = '0;
      out.data.applied_y = '0;
      out.data.applied_z = '0;
    end else begin
      out.data.new_a = ra;
      out.data.new_b = rb;
      out.data.new_c = rc;
    end
  end

  // a stalled output holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out.valid && !out.ready |=> out.valid && $stable(out.data))
    else $error("output changed under stall");
  // input blocked while stalled
  a_block: assert property (@(posedge clk) disable iff (rst)
    out.valid && !out.ready |-> !in.ready)
    else $error("input accepted under stall");
  // untouched implies zero applied rates
  a_untouched: assert property (@(posedge clk) disable iff (rst)
    out.valid && out.data.untouched |-> out.data.applied_x == 16'sd0 &&
    out.data.applied_y == 16'sd0 && out.data.applied_z == 16'sd0)
    else $error("untouched with nonzero rate");

endmodule

// File: tb/sv/tb_column_rotation.sv
// ---------------------------------------------------------------------------
// tb_column_rotation: self-checking bench for the Euler column rotator
// Drives column items with random gaps, predicts each rotated column with a
// local fixed-point CORDIC model and compares every result field in order.
// ---------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint PI_FX   = 64'sd3373259426;
  localparam longint HALF_PI = 64'sd1686629713;
  localparam longint GAIN_K  = 64'sd652032875;
  localparam longint ONE_FX  = 64'sd1073741824;
  localparam int     LATENCY = 38;

  logic clk = 1'b0;
  logic rst = 1'b1;

  ero_stream_if #(.item_t(ero_pkg::in_item_t))  in_ch ();
  ero_stream_if #(.item_t(ero_pkg::out_item_t)) out_ch ();

  euler_rotate_orientation_column_top dut (
    .clk(clk), .rst(rst), .in(in_ch.sink), .out(out_ch.source)
  );

  always #4 clk = ~clk;

  ero_pkg::out_item_t rotated_q[$];
  int        fail_cnt  = 0;
  int        sent_cnt  = 0;
  int        got_cnt   = 0;
  int        flag_cnt  = 0;
  bit        idle_on   = 1'b1;
  int        hold_len  = 0;

  longint arctan_tab[30] = '{
    843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
    16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
    65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32,
    16, 8, 4, 2};

  // Floor product of two Q30 values
  function automatic longint fx_mul(longint a, longint b);
    return (a * b) >>> 30;
  endfunction

  // Sine and cosine of rate*(-pi/32767) by rotation CORDIC
  function automatic void rate_sincos(longint r, output longint s, output longint c);
    longint ang, x, y, t;
    bit     flip;
    ang  = -(r * PI_FX) / 64'sd32767;
    x    = GAIN_K;
    y    = 0;
    flip = 1'b0;
    if (ang == 0) begin
      s = 0;
      c = ONE_FX;
      return;
    end
    if (ang > HALF_PI) begin
      ang -= PI_FX;
      flip = 1'b1;
    end else if (ang < -HALF_PI) begin
      ang += PI_FX;
      flip = 1'b1;
    end
    for (int i = 0; i < 30; i++) begin
      if (ang >= 0) begin
        t = x - (y >>> i); y = y + (x >>> i); x = t; ang -= arctan_tab[i];
      end else begin
        t = x + (y >>> i); y = y - (x >>> i); x = t; ang += arctan_tab[i];
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    s = y;
    c = x;
  endfunction

  // Truncate toward zero and saturate to int32
  function automatic logic signed [31:0] trunc_sat(longint v);
    longint q;
    q = (v >= 0) ? (v >>> 30) : -((-v) >>> 30);
    if (q > 64'sd2147483647) q = 64'sd2147483647;
    if (q < -64'sd2147483648) q = -64'sd2147483648;
    return q[31:0];
  endfunction

  function automatic longint clamp_cap(longint r, longint cap);
    if (r < -cap) return -cap;
    if (r > cap) return cap;
    return r;
  endfunction

  function automatic ero_pkg::out_item_t rotate_column(ero_pkg::in_item_t it);
    ero_pkg::out_item_t o;
    longint a, b, c, rx, ry, rz, cap;
    longint sx, cx, sy, cy, sz, cz, szsx, czsx;
    longint x1, x2, x3, y1, y2, y3, z1, z2, z3;
    a = it.col_a; b = it.col_b; c = it.col_c;
    rx = it.rate_x; ry = it.rate_y; rz = it.rate_z;
    cap = {49'd0, it.time_cap};
    if (rx == 0 && ry == 0 && rz == 0) begin
      o = '{new_a: it.col_a, new_b: it.col_b, new_c: it.col_c,
            applied_x: 16'sd0, applied_y: 16'sd0, applied_z: 16'sd0, untouched: 1'b1};
      return o;
    end
    rx = clamp_cap(rx, cap);
    ry = clamp_cap(ry, cap);
    rz = clamp_cap(rz, cap);
    rate_sincos(rx, sx, cx);
    rate_sincos(ry, sy, cy);
    rate_sincos(rz, sz, cz);
    szsx = fx_mul(sz, sx);
    czsx = fx_mul(cz, sx);
    x1 = fx_mul(cz, cy) + fx_mul(szsx, sy);
    x2 = fx_mul(sz, cx);
    x3 = -fx_mul(cz, sy) + fx_mul(szsx, cy);
    y1 = -fx_mul(sz, cy) + fx_mul(czsx, sy);
    y2 = fx_mul(cz, cx);
    y3 = fx_mul(sz, sy) + fx_mul(czsx, cy);
    z1 = fx_mul(cx, sy);
    z2 = -sx;
    z3 = fx_mul(cx, cy);
    o.new_a     = trunc_sat(x1 * a + y1 * b + z1 * c);
    o.new_b     = trunc_sat(x2 * a + y2 * b + z2 * c);
    o.new_c     = trunc_sat(x3 * a + y3 * b + z3 * c);
    o.applied_x = rx[15:0];
    o.applied_y = ry[15:0];
    o.applied_z = rz[15:0];
    o.untouched = 1'b0;
    return o;
  endfunction

  // Offer one item, optionally after a random gap, and wait for acceptance
  task automatic send_column(ero_pkg::in_item_t it);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    in_ch.data  <= it;
    in_ch.valid <= 1'b1;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    rotated_q.push_back(rotate_column(it));
    sent_cnt++;
    @(negedge clk);
  endtask

  function automatic ero_pkg::in_item_t make_item(int ca, int cb, int cc, int rx, int ry,
                                                  int rz, int cap);
    ero_pkg::in_item_t it;
    it.col_a = ca; it.col_b = cb; it.col_c = cc;
    it.rate_x = rx[15:0]; it.rate_y = ry[15:0]; it.rate_z = rz[15:0];
    it.time_cap = cap[14:0];
    return it;
  endfunction

  function automatic int rand_col();
    case ($urandom_range(0, 4))
      0: return 32'sh7fff8000;
      1: return -32'sh7fff8000;
      2: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      default: return $urandom();
    endcase
  endfunction

  function automatic int rand_rate();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return $urandom_range(0, 1) ? 32767 : -32767;
      2: return -32768;
      3: return $signed(16'($urandom_range(0, 200))) - 100;
      default: return $signed(16'($urandom()));
    endcase
  endfunction

  // Directed corners: scale extremes, zero rates, cap extremes, half turns
  task automatic test_directed();
    send_column(make_item(32'sh7fff8000, 0, 0, 0, 0, 0, 100));
    send_column(make_item(32'sh7fffffff, 32'sh80000000, -1, 0, 0, 0, 0));
    send_column(make_item(32'sh7fff8000, 32'sh7fff8000, 32'sh7fff8000, 5, 0, 0, 0));
    send_column(make_item(32'sh7fff8000, 0, 0, 32767, 0, 0, 32767));
    send_column(make_item(0, 32'sh7fff8000, 0, 0, -32767, 0, 32767));
    send_column(make_item(0, 0, 32'sh7fff8000, 0, 0, -32768, 32767));
    send_column(make_item(32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 8000, 8000, 8000, 32767));
    send_column(make_item(32'sh80000000, 32'sh80000000, 32'sh80000000, -8000, 8000, -8000,
                          32767));
    send_column(make_item(32'sh7fff8000, 32'sh12345678, -5, 16383, 16384, -16384, 32767));
    send_column(make_item(123456, -654321, 999, 20000, -20000, 300, 1000));
    send_column(make_item(-1, 1, 0, -32768, -32768, -32768, 0));
    send_column(make_item(32'sh7fff8000, 32'sh7fff8000, 0, 1, -1, 1, 1));
    send_column(make_item(32'sh55555555, 32'shaaaaaaaa, 32'sh0f0f0f0f, 32767, 32767, 32767,
                          16383));
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++)
      send_column(make_item(rand_col(), rand_col(), rand_col(), rand_rate(), rand_rate(),
                            rand_rate(), $urandom_range(0, 32767) | ($urandom_range(0, 3) == 0
                            ? 15'h7fff : 15'h0)));
  endtask

  // Receiver stalls for a long stretch while items keep coming
  task automatic test_backpressure();
    hold_len = 120;
    test_random(80);
  endtask

  task automatic test_full_rate();
    idle_on = 1'b0;
    test_random(400);
  endtask

  // Receiver ready: random stalls, one long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_len > 0) begin
        out_ch.ready <= 1'b0;
        repeat (hold_len) @(negedge clk);
        hold_len = 0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(negedge clk);
      end
      out_ch.ready <= !rst;
    end
  end

  // Compare each accepted result with the oldest prediction
  always @(posedge clk) begin
    ero_pkg::out_item_t exp_o, got;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      got_cnt++;
      if (got.untouched) flag_cnt++;
      if (rotated_q.size() == 0) begin
        $error("result with nothing expected");
        fail_cnt++;
      end else begin
        exp_o = rotated_q.pop_front();
        if (got.new_a !== exp_o.new_a) begin
          $error("new_a exp %0d got %0d", exp_o.new_a, got.new_a); fail_cnt++;
        end
        if (got.new_b !== exp_o.new_b) begin
          $error("new_b exp %0d got %0d", exp_o.new_b, got.new_b); fail_cnt++;
        end
        if (got.new_c !== exp_o.new_c) begin
          $error("new_c exp %0d got %0d", exp_o.new_c, got.new_c); fail_cnt++;
        end
        if (got.applied_x !== exp_o.applied_x) begin
          $error("applied_x exp %0d got %0d", exp_o.applied_x, got.applied_x); fail_cnt++;
        end
        if (got.applied_y !== exp_o.applied_y) begin
          $error("applied_y exp %0d got %0d", exp_o.applied_y, got.applied_y); fail_cnt++;
        end
        if (got.applied_z !== exp_o.applied_z) begin
          $error("applied_z exp %0d got %0d", exp_o.applied_z, got.applied_z); fail_cnt++;
        end
        if (got.untouched !== exp_o.untouched) begin
          $error("untouched exp %0d got %0d", exp_o.untouched, got.untouched); fail_cnt++;
        end
      end
    end
  end

  // Timeout
  initial begin
    #2ms;
    $display("tb NOT OK");
    $finish;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_random(1000);
    test_backpressure();
    test_random(200);
    test_full_rate();
    in_ch.valid <= 1'b0;
    while (rotated_q.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
    if (rotated_q.size() != 0) fail_cnt++;
    $display("Sent %0d column items, checked %0d results (%0d pass-through).",
             sent_cnt, got_cnt, flag_cnt);
    if (fail_cnt == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

// File: files.f
rtl/core/ero_pkg.sv
rtl/core/ero_stream_if.sv
rtl/core/ero_sincos_lane.sv
rtl/core/ero_merge.sv
rtl/core/euler_rotate_orientation_column_top.sv
tb/sv/tb_column_rotation.sv
